>>> rtl/core/pfa_pkg.sv
// Package: shared widths, command and mode codes for the partition fit allocator.
`default_nettype none
package pfa_pkg;

	localparam int unsigned SIZE_BITS   = 16;
	localparam int unsigned CMD_BITS    = 2;
	localparam int unsigned SLOT_BITS   = 4;
	localparam int unsigned BLKNUM_BITS = 5;
	localparam int unsigned COUNT_BITS  = 16;
	localparam int unsigned TOTAL_BITS  = 20;
	localparam int unsigned CFG_IDX_BITS  = 4;
	localparam int unsigned CFG_DATA_BITS = 5;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// input commands
	localparam logic [CMD_BITS-1:0] CMD_LOAD     = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ALLOCATE = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_REPORT   = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_RESTART  = 2'd3;

	// placement policies
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_NEXT  = 2'd1;
	localparam logic [1:0] MODE_BEST  = 2'd2;
	localparam logic [1:0] MODE_WORST = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE    = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT = 4'd1;

	localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

	// result kinds
	localparam logic RESULT_ALLOC  = 1'b0;
	localparam logic RESULT_TOTALS = 1'b1;

endpackage
`default_nettype wire

>>> rtl/core/pfa_item_if.sv
// Interface: input item channel (command, slot, size).
`default_nettype none
interface pfa_item_if;
	logic                              valid;
	logic                              ready;
	logic [pfa_pkg::CMD_BITS-1:0]      cmd;
	logic [pfa_pkg::SLOT_BITS-1:0]     slot;
	logic [pfa_pkg::SIZE_BITS-1:0]     size;

	modport source (output valid, output cmd, output slot, output size, input ready);
	modport sink   (input valid, input cmd, input slot, input size, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pfa_result_if.sv
// Interface: result item channel (allocation result or fragmentation totals).
`default_nettype none
interface pfa_result_if;
	logic                               valid;
	logic                               ready;
	logic                               result_kind;
	logic                               granted;
	logic [pfa_pkg::BLKNUM_BITS-1:0]    block_number;
	logic [pfa_pkg::COUNT_BITS-1:0]     request_number;
	logic [pfa_pkg::SIZE_BITS-1:0]      leftover;
	logic [pfa_pkg::TOTAL_BITS-1:0]     internal_total;
	logic [pfa_pkg::TOTAL_BITS-1:0]     external_total;

	modport source (output valid, output result_kind, output granted, output block_number,
		output request_number, output leftover, output internal_total,
		output external_total, input ready);
	modport sink   (input valid, input result_kind, input granted, input block_number,
		input request_number, input leftover, input internal_total,
		input external_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pfa_cfg_if.sv
// Interface: configuration write channel (register index and data).
`default_nettype none
interface pfa_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pfa_pkg::CFG_IDX_BITS-1:0]    index;
	logic [pfa_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/partition_fit_allocator_core.sv
// Top level: fixed-partition allocator with first, next, best and worst fit placement.
// Load and restart transactions complete in the accept cycle and give no result.
// Allocate and report transactions scan the first n slots and then register their result,
// n being the block count register capped at SLOTS (no scan when it is zero); one size memory entry per
// cycle goes through the shared compare and add unit, the input is ready again as soon as
// the result is registered, and a result held by the receiver stalls the sequencer.
// Reset (arst_n low) clears control state, marks every slot used and loads the
// register reset values; the size memory holds no reset and needs no clearing pass.
`default_nettype none
module partition_fit_allocator_core #(
	parameter int unsigned SLOTS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pfa_item_if.sink        item,
	pfa_result_if.source    result,
	pfa_cfg_if.sink         cfg
);

	localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned SB = pfa_pkg::SIZE_BITS;
	localparam int unsigned SW = SB + CW;
	localparam int unsigned IW = pfa_pkg::TOTAL_BITS + 1;
	localparam logic [8:0]  SLOTS_W = 9'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic [1:0] fit_mode_q;
	logic [4:0] block_count_q;

	// allocator state
	logic [SB-1:0]                    loaded_mem [SLOTS];
	logic [SLOTS-1:0]                 used_q;
	logic [AW-1:0]                    next_ptr_q;
	logic [pfa_pkg::TOTAL_BITS-1:0]   int_sum_q;
	logic [pfa_pkg::COUNT_BITS-1:0]   req_count_q;

	// per-transaction context
	logic                             kind_q;
	logic [SB-1:0]                    req_q;
	logic [CW-1:0]                    n_q;
	logic [AW-1:0]                    start_q;
	logic [CW-1:0]                    rd_idx_q;

	// scan read stage
	logic                             issue_s1;
	logic [AW-1:0]                    idx_s1;
	logic [SB-1:0]                    rdata_s1;

	// scan accumulators
	logic                             pick_v_q;
	logic [AW-1:0]                    pick_idx_q;
	logic [SB-1:0]                    pick_size_q;
	logic                             alt_v_q;
	logic [AW-1:0]                    alt_idx_q;
	logic [SB-1:0]                    alt_size_q;
	logic [SW-1:0]                    sum_q;

	// output register
	logic                             out_valid_q;
	logic                             out_kind_q;
	logic                             out_granted_q;
	logic [pfa_pkg::BLKNUM_BITS-1:0]  out_block_q;
	logic [pfa_pkg::COUNT_BITS-1:0]   out_reqnum_q;
	logic [SB-1:0]                    out_left_q;
	logic [pfa_pkg::TOTAL_BITS-1:0]   out_int_q;
	logic [pfa_pkg::TOTAL_BITS-1:0]   out_ext_q;

	logic                             item_fire;
	logic                             out_free;
	logic [8:0]                       slot_w;
	logic                             slot_ok;
	logic [AW-1:0]                    wr_addr;
	logic [8:0]                       bc_w;
	logic [CW-1:0]                    n_new;
	logic [AW-1:0]                    start_new;
	logic                             do_issue;
	logic [AW-1:0]                    rd_addr;

	logic [SB-1:0]                    rem_s1;
	logic                             fit_s1;
	logic                             cmp_less;
	logic                             take_pick;
	logic                             take_alt;

	logic                             fin_use_alt;
	logic                             fin_v;
	logic [AW-1:0]                    fin_idx;
	logic [SB-1:0]                    fin_size;
	logic                             fin_grant;
	logic [SB-1:0]                    fin_left;
	logic [IW-1:0]                    int_add;
	logic [pfa_pkg::TOTAL_BITS-1:0]   int_next;
	logic [SW-1:0]                    ext_raw;
	logic [pfa_pkg::TOTAL_BITS-1:0]   ext_sat;
	logic [AW:0]                      blk_plus;
	logic                             finish_go;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// decode load address and the slot count in use
	assign slot_w    = {5'd0, item.slot};
	assign slot_ok   = slot_w < SLOTS_W;
	assign wr_addr   = slot_w[AW-1:0];
	assign bc_w      = {4'd0, block_count_q};
	assign n_new     = (bc_w > SLOTS_W) ? CW'(SLOTS) : CW'(bc_w);
	assign start_new = ({{(CW-AW){1'b0}}, next_ptr_q} < n_new) ? next_ptr_q : '0;

	// scan issue address
	assign do_issue = (state_q == ST_SCAN) && (rd_idx_q < n_q);
	assign rd_addr  = rd_idx_q[AW-1:0];

	// shared compare unit on the entry returned by the memory
	assign rem_s1   = used_q[idx_s1] ? '0 : rdata_s1;
	assign fit_s1   = (rem_s1 != '0) && (req_q <= rem_s1);
	assign cmp_less = rem_s1 < pick_size_q;

	always_comb begin
		take_pick = 1'b0;
		take_alt  = 1'b0;
		case (fit_mode_q)
			pfa_pkg::MODE_FIRST: begin
				take_pick = fit_s1 && !pick_v_q;
			end
			pfa_pkg::MODE_NEXT: begin
				take_pick = fit_s1 && (idx_s1 >= start_q) && !pick_v_q;
				take_alt  = fit_s1 && !alt_v_q;
			end
			pfa_pkg::MODE_BEST: begin
				take_pick = fit_s1 && (!pick_v_q || cmp_less);
			end
			pfa_pkg::MODE_WORST: begin
				take_pick = fit_s1 && (!pick_v_q || !cmp_less);
			end
			default: begin
				take_pick = 1'b0;
			end
		endcase
	end

	// resolve the choice and the totals
	assign fin_use_alt = (fit_mode_q == pfa_pkg::MODE_NEXT) && !pick_v_q;
	assign fin_v       = fin_use_alt ? alt_v_q    : pick_v_q;
	assign fin_idx     = fin_use_alt ? alt_idx_q  : pick_idx_q;
	assign fin_size    = fin_use_alt ? alt_size_q : pick_size_q;
	assign fin_grant   = (kind_q == pfa_pkg::RESULT_ALLOC) && fin_v;
	assign fin_left    = fin_grant ? (fin_size - req_q) : '0;
	assign int_add     = {1'b0, int_sum_q} + IW'(fin_left);
	assign int_next    = int_add[IW-1] ? pfa_pkg::TOTAL_MAX : int_add[IW-2:0];
	assign ext_raw     = fin_grant ? (sum_q - SW'(fin_size)) : sum_q;
	assign ext_sat     = (32'(ext_raw) > 32'(pfa_pkg::TOTAL_MAX)) ? pfa_pkg::TOTAL_MAX
		: pfa_pkg::TOTAL_BITS'(ext_raw);
	assign blk_plus    = {1'b0, fin_idx} + (AW+1)'(1);
	assign finish_go   = (state_q == ST_FINISH) && out_free;

	// size memory: write on load, registered read during the scan
	always_ff @(posedge clk) begin
		if (item_fire && (item.cmd == pfa_pkg::CMD_LOAD) && slot_ok) begin
			loaded_mem[wr_addr] <= item.size;
		end
		rdata_s1 <= loaded_mem[rd_addr];
		idx_s1   <= rd_addr;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= pfa_pkg::MODE_FIRST;
			block_count_q <= pfa_pkg::BLOCK_COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == pfa_pkg::CFG_FIT_MODE) begin
				fit_mode_q <= cfg.data[1:0];
			end else if (cfg.index == pfa_pkg::CFG_BLOCK_COUNT) begin
				block_count_q <= cfg.data;
			end
		end
	end

	// sequencer, slot state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '1;
			next_ptr_q  <= '0;
			int_sum_q   <= '0;
			req_count_q <= '0;
			issue_s1    <= 1'b0;
			rd_idx_q    <= '0;
			pick_v_q    <= 1'b0;
			alt_v_q     <= 1'b0;
		end else begin
			issue_s1 <= do_issue;
			case (state_q)
				ST_IDLE: begin
					if (item_fire) begin
						case (item.cmd)
							pfa_pkg::CMD_LOAD: begin
								if (slot_ok) begin
									used_q[wr_addr] <= 1'b0;
								end
							end
							pfa_pkg::CMD_RESTART: begin
								used_q      <= '0;
								next_ptr_q  <= '0;
								int_sum_q   <= '0;
								req_count_q <= '0;
							end
							pfa_pkg::CMD_ALLOCATE, pfa_pkg::CMD_REPORT: begin
								if (item.cmd == pfa_pkg::CMD_ALLOCATE &&
									req_count_q != pfa_pkg::COUNT_MAX) begin
									req_count_q <= req_count_q + pfa_pkg::COUNT_BITS'(1);
								end
								rd_idx_q <= '0;
								pick_v_q <= 1'b0;
								alt_v_q  <= 1'b0;
								state_q  <= (n_new == '0) ? ST_FINISH : ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (do_issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (issue_s1) begin
						if (take_pick) begin
							pick_v_q <= 1'b1;
						end
						if (take_alt) begin
							alt_v_q <= 1'b1;
						end
					end
					if (!do_issue && !issue_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						if (fin_grant) begin
							used_q[fin_idx] <= 1'b1;
							int_sum_q       <= int_next;
							if (fit_mode_q == pfa_pkg::MODE_NEXT) begin
								next_ptr_q <= fin_idx;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction context and scan payload
	always_ff @(posedge clk) begin
		if (item_fire) begin
			kind_q  <= (item.cmd == pfa_pkg::CMD_REPORT) ? pfa_pkg::RESULT_TOTALS
				: pfa_pkg::RESULT_ALLOC;
			req_q   <= item.size;
			n_q     <= n_new;
			start_q <= start_new;
			sum_q   <= '0;
		end else if ((state_q == ST_SCAN) && issue_s1) begin
			sum_q <= sum_q + SW'(rem_s1);
			if (take_pick) begin
				pick_idx_q  <= idx_s1;
				pick_size_q <= rem_s1;
			end
			if (take_alt) begin
				alt_idx_q  <= idx_s1;
				alt_size_q <= rem_s1;
			end
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_kind_q    <= kind_q;
			out_granted_q <= fin_grant;
			out_block_q   <= fin_grant ? pfa_pkg::BLKNUM_BITS'(blk_plus) : '0;
			out_reqnum_q  <= req_count_q;
			out_left_q    <= fin_left;
			out_int_q     <= fin_grant ? int_next : int_sum_q;
			out_ext_q     <= ext_sat;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.result_kind    = out_kind_q;
	assign result.granted        = out_granted_q;
	assign result.block_number   = out_block_q;
	assign result.request_number = out_reqnum_q;
	assign result.leftover       = out_left_q;
	assign result.internal_total = out_int_q;
	assign result.external_total = out_ext_q;

	// checks
	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1 |-> state_q == ST_SCAN)
		else $error("scan read returned outside the scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_idx_q <= n_q)
		else $error("scan index ran past the slots in use");

	a_grant_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go && fin_grant |=> used_q[$past(fin_idx)])
		else $error("granted slot not marked used");

	a_grant_block: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> (out_granted_q == (out_block_q != '0)) || (SLOTS > 31))
		else $error("block number disagrees with grant");

	a_totals_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go && (kind_q == pfa_pkg::RESULT_TOTALS) |=> !out_granted_q &&
			out_left_q == '0)
		else $error("totals result carries an allocation");

endmodule
`default_nettype wire
